FILE: sv/four_level_page_table_engine_top_assert.svh
// assertion macros shared by the page table engine modules
`ifndef FOUR_LEVEL_PAGE_TABLE_ENGINE_TOP_ASSERT_SVH
`define FOUR_LEVEL_PAGE_TABLE_ENGINE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define FLPTE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define FLPTE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define FLPTE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define FLPTE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

FILE: sv/fl_pte_pkg.sv
// types, codes and constants of the page table engine
`timescale 1ns / 1ps
package fl_pte_pkg;

  localparam int TABLE_FRAMES_DEF      = 64;
  localparam int FRAME_NUMBER_BITS_DEF = 40;
  localparam int CFG_BITS              = 40;
  localparam int VA_BITS               = 48;
  localparam int PA_BITS               = 52;
  localparam int IDX_BITS              = 9;
  localparam int OFFSET_BITS           = 12;
  localparam int ENTRY_FLAG_BITS       = 3;
  localparam logic [1:0] LEVEL_LAST    = 2'd3;

  typedef enum logic [1:0] {
    REQ_MAP       = 2'd0,
    REQ_UNMAP     = 2'd1,
    REQ_TRANSLATE = 2'd2,
    REQ_NONE      = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK            = 2'd0,
    STAT_NOT_MAPPED    = 2'd1,
    STAT_OUT_OF_FRAMES = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic req_nop;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage

FILE: sv/four_level_page_table_engine_top.sv
// top level of the four-level page table engine
//
//  port group        dir  role
//  cfg_write_*       in   table_base_frame register write
//  in_valid/stall    in   request transaction: req_type, virt_addr, phys_addr_in, user_flag
//  out_valid/stall   out  result transaction: phys_addr_out, status
//
// after reset the table store is cleared one entry a cycle with in_stall high;
// config writes are taken meanwhile.
// a request passes a read state and an evaluate state for each table level, then a finish state;
// the single read port of the store with its registered read is why each level needs both states.
// a finished result sits in the output register while the next request is taken;
// the walk only waits in its last state when the output register is still held.
`timescale 1ns / 1ps
module four_level_page_table_engine_top import fl_pte_pkg::*; #(
  parameter int TABLE_FRAMES      = TABLE_FRAMES_DEF,
  parameter int FRAME_NUMBER_BITS = FRAME_NUMBER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [CFG_BITS-1:0] cfg_write_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          req_type,
  input  logic [VA_BITS-1:0]  virt_addr,
  input  logic [PA_BITS-1:0]  phys_addr_in,
  input  logic                user_flag,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PA_BITS-1:0]  phys_addr_out,
  output logic [1:0]          status
);

  cmd_t cmd;
  sts_t sts;

  fl_pte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fl_pte_dp #(
    .TABLE_FRAMES      (TABLE_FRAMES),
    .FRAME_NUMBER_BITS (FRAME_NUMBER_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req_type       (req_type),
    .virt_addr      (virt_addr),
    .phys_addr_in   (phys_addr_in),
    .user_flag      (user_flag),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .phys_addr_out  (phys_addr_out),
    .status         (status),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

FILE: sv/fl_pte_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module fl_pte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/fl_pte_ctrl.sv
// walk controller state machine
`timescale 1ns / 1ps
`include "four_level_page_table_engine_top_assert.svh"
module fl_pte_ctrl import fl_pte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (sts.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = S_READ;
      end
      S_READ: begin
        state_next = sts.req_nop ? S_FINISH : S_EVAL;
      end
      S_EVAL: begin
        state_next = sts.walk_done ? S_FINISH : S_READ;
      end
      S_FINISH: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
      end
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_EVAL: begin
        cmd.step = 1'b1;
      end
      S_FINISH: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `FLPTE_ASSERT_IMPL(a_eval_after_read, clk, rst, state == S_EVAL, $past(state) == S_READ)
  `FLPTE_ASSERT_NEXT(a_done_to_finish, clk, rst, state == S_EVAL && sts.walk_done, state == S_FINISH)
  `FLPTE_ASSERT_NEXT(a_accept_to_read, clk, rst, cmd.accept, state == S_READ)

endmodule

FILE: sv/fl_pte_dp.sv
// walk datapath: request registers, table store, allocator, result register
`timescale 1ns / 1ps
`include "four_level_page_table_engine_top_assert.svh"
module fl_pte_dp import fl_pte_pkg::*; #(
  parameter int TABLE_FRAMES      = TABLE_FRAMES_DEF,
  parameter int FRAME_NUMBER_BITS = FRAME_NUMBER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_en,
  input  logic [CFG_BITS-1:0] cfg_write_data,
  input  logic [1:0]          req_type,
  input  logic [VA_BITS-1:0]  virt_addr,
  input  logic [PA_BITS-1:0]  phys_addr_in,
  input  logic                user_flag,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PA_BITS-1:0]  phys_addr_out,
  output logic [1:0]          status,
  input  cmd_t                cmd,
  output sts_t                sts
);

  localparam int FNB       = FRAME_NUMBER_BITS;
  localparam int EW        = FNB + ENTRY_FLAG_BITS;
  localparam int DEPTH     = TABLE_FRAMES * (2 ** IDX_BITS);
  localparam int AW        = $clog2(DEPTH);
  localparam int SLOT_BITS = AW - IDX_BITS;
  localparam int NFS_BITS  = $clog2(TABLE_FRAMES + 1);

  // request and walk registers
  req_t                  req;
  logic [VA_BITS-1:0]    va;
  logic [PA_BITS-1:0]    pa;
  logic                  user;
  logic [1:0]            level;
  logic [SLOT_BITS-1:0]  slot;
  logic [NFS_BITS-1:0]   nfs;
  logic [FNB-1:0]        base;
  logic [AW-1:0]         clr_addr;
  logic [PA_BITS-1:0]    phys_r;
  stat_t                 stat_r;

  logic [IDX_BITS-1:0]   idx;
  logic [AW-1:0]         pos;
  logic [EW-1:0]         rd_data;
  logic                  present;
  logic [FNB-1:0]        efr;
  logic [FNB-1:0]        frame_ofs;
  logic                  in_store;
  logic                  alloc_ok;
  logic [FNB-1:0]        alloc_frame;
  logic                  last;
  logic                  need_alloc;
  logic [FNB-1:0]        new_frame;
  logic [EW-1:0]         new_entry;

  logic                  walk_done;
  logic                  walk_wr;
  logic [EW-1:0]         walk_wdata;
  logic                  take_alloc;
  logic [SLOT_BITS-1:0]  slot_nxt;
  stat_t                 res_stat;
  logic [PA_BITS-1:0]    res_phys;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [EW-1:0]         ram_wdata;

  always_comb begin
    case (level)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
  end

  assign pos = {slot, idx};

  fl_pte_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (pos),
    .rdata (rd_data)
  );

  assign present     = rd_data[0];
  assign efr         = rd_data[EW-1:ENTRY_FLAG_BITS];
  assign frame_ofs   = efr - base;
  assign in_store    = frame_ofs < FNB'(TABLE_FRAMES);
  assign alloc_ok    = nfs < NFS_BITS'(TABLE_FRAMES);
  assign alloc_frame = base + FNB'(nfs);
  assign last        = (level == LEVEL_LAST);
  assign need_alloc  = !last || (pa == '0);
  assign new_frame   = need_alloc ? alloc_frame : pa[FNB+OFFSET_BITS-1:OFFSET_BITS];
  assign new_entry   = {new_frame, user, 1'b1, 1'b1};

  // one level of the walk, evaluated on the entry just read
  always_comb begin
    walk_done  = 1'b0;
    walk_wr    = 1'b0;
    walk_wdata = new_entry;
    take_alloc = 1'b0;
    slot_nxt   = frame_ofs[SLOT_BITS-1:0];
    res_stat   = STAT_OK;
    res_phys   = '0;
    case (req)
      REQ_MAP: begin
        if (!present) begin
          if (need_alloc && !alloc_ok) begin
            walk_done = 1'b1;
            res_stat  = STAT_OUT_OF_FRAMES;
          end else begin
            walk_wr    = 1'b1;
            take_alloc = need_alloc;
            walk_done  = last;
            // freshly allocated table lives at the allocator slot
            slot_nxt   = nfs[SLOT_BITS-1:0];
          end
        end else if (last) begin
          walk_done = 1'b1;
        end else if (!in_store) begin
          walk_done = 1'b1;
          res_stat  = STAT_NOT_MAPPED;
        end
      end
      REQ_UNMAP: begin
        if (!present) begin
          walk_done = 1'b1;
          res_stat  = STAT_NOT_MAPPED;
        end else if (last) begin
          walk_done  = 1'b1;
          walk_wr    = 1'b1;
          walk_wdata = '0;
        end else if (!in_store) begin
          walk_done = 1'b1;
          res_stat  = STAT_NOT_MAPPED;
        end
      end
      REQ_TRANSLATE: begin
        if (!present) begin
          walk_done = 1'b1;
          res_stat  = STAT_NOT_MAPPED;
        end else if (last) begin
          walk_done = 1'b1;
          res_phys  = PA_BITS'({efr, va[OFFSET_BITS-1:0]});
        end else if (!in_store) begin
          walk_done = 1'b1;
          res_stat  = STAT_NOT_MAPPED;
        end
      end
      default: begin
        walk_done = 1'b1;
      end
    endcase
  end

  // clearing pass owns the write port until it finishes
  assign ram_we    = cmd.clear_wr || (cmd.step && walk_wr);
  assign ram_waddr = cmd.clear_wr ? clr_addr : pos;
  assign ram_wdata = cmd.clear_wr ? '0 : walk_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      base <= '0;
    end else if (cfg_write_en) begin
      base <= cfg_write_data[FNB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nfs <= NFS_BITS'(1);
    end else if (cmd.step && take_alloc) begin
      nfs <= nfs + NFS_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      slot   <= '0;
      req    <= REQ_NONE;
      stat_r <= STAT_OK;
    end else if (cmd.accept) begin
      level  <= '0;
      slot   <= '0;
      req    <= req_t'(req_type);
      stat_r <= STAT_OK;
    end else if (cmd.step) begin
      if (walk_done) begin
        stat_r <= res_stat;
      end else begin
        level <= level + 2'd1;
        slot  <= slot_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      va     <= virt_addr;
      pa     <= phys_addr_in;
      user   <= user_flag;
      phys_r <= '0;
    end else if (cmd.step && walk_done) begin
      phys_r <= res_phys;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      phys_addr_out <= phys_r;
      status        <= stat_r;
    end
  end

  assign sts.clear_done = (clr_addr == AW'(DEPTH - 1));
  assign sts.req_nop    = (req == REQ_NONE);
  assign sts.walk_done  = walk_done;
  assign sts.out_free   = !out_valid || !out_stall;

  `FLPTE_ASSERT_IMPL(a_alloc_bound, clk, rst, 1'b1, nfs <= NFS_BITS'(TABLE_FRAMES))
  `FLPTE_ASSERT_NEXT(a_level_adv, clk, rst, cmd.step && !walk_done, level == $past(level) + 2'd1)
  `FLPTE_ASSERT_NEXT(a_finish_valid, clk, rst, cmd.finish, out_valid)

endmodule

FILE: dv/tb_four_level_page_table_engine_top.sv
// self-checking testbench for the four-level page table engine top level
`timescale 1ns / 1ps
module tb_four_level_page_table_engine_top;
  import fl_pte_pkg::*;

  localparam int STORE_ENTRIES = TABLE_FRAMES_DEF * 512;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic [PA_BITS-1:0] addr;
    stat_t              st;
  } walk_result_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_write_en = 1'b0;
  logic [CFG_BITS-1:0] cfg_write_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          req_type = REQ_NONE;
  logic [VA_BITS-1:0]  virt_addr = '0;
  logic [PA_BITS-1:0]  phys_addr_in = '0;
  logic                user_flag = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PA_BITS-1:0]  phys_addr_out;
  logic [1:0]          status;

  // shadow copy of the engine state
  logic [42:0]         page_store [STORE_ENTRIES];
  int unsigned         free_slot;
  logic [CFG_BITS-1:0] base_frame;

  walk_result_t        expected_results [$];
  stat_t               last_status;
  int                  sender_idle_pct = 0;
  int                  receiver_stall_pct = 0;
  int                  errors = 0;
  int                  results_checked = 0;
  int                  cycle_count = 0;
  int                  kind_sent [4] = '{0, 0, 0, 0};
  int                  status_seen [4] = '{0, 0, 0, 0};

  four_level_page_table_engine_top dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .virt_addr     (virt_addr),
    .phys_addr_in  (phys_addr_in),
    .user_flag     (user_flag),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .phys_addr_out (phys_addr_out),
    .status        (status)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("[four_level_page_table_engine_top] ERROR");
      $finish;
    end
  end

  // walks the shadow tables exactly as the engine does and updates them
  function automatic walk_result_t walk_page_tables(req_t kind, logic [VA_BITS-1:0] va,
                                                    logic [PA_BITS-1:0] pa, logic usr);
    walk_result_t        res;
    logic [8:0]          idx [4];
    int unsigned         slot;
    int unsigned         pos;
    logic [42:0]         ent;
    logic [CFG_BITS-1:0] frame;
    logic [CFG_BITS-1:0] frame_ofs;
    int                  lvl;
    res.addr = '0;
    res.st = STAT_OK;
    slot = 0;
    for (lvl = 0; lvl < 4; lvl++) begin
      idx[lvl] = va[47 - 9 * lvl -: 9];
    end
    if (kind != REQ_NONE) begin
      for (lvl = 0; lvl < 4; lvl++) begin
        pos = slot * 512 + idx[lvl];
        ent = page_store[pos];
        if (!ent[0]) begin
          if (kind != REQ_MAP) begin
            res.st = STAT_NOT_MAPPED;
            break;
          end
          if (lvl < 3 || pa == '0) begin
            if (free_slot >= TABLE_FRAMES_DEF) begin
              res.st = STAT_OUT_OF_FRAMES;
              break;
            end
            frame = base_frame + 40'(free_slot);
            free_slot++;
          end else begin
            frame = pa[51:12];
          end
          ent = {frame, usr, 1'b1, 1'b1};
          page_store[pos] = ent;
        end
        if (lvl < 3) begin
          // pointer must land inside the store under the current base
          frame_ofs = ent[42:3] - base_frame;
          if (frame_ofs >= TABLE_FRAMES_DEF) begin
            res.st = STAT_NOT_MAPPED;
            break;
          end
          slot = 32'(frame_ofs);
        end else if (kind == REQ_UNMAP) begin
          page_store[pos] = '0;
        end else if (kind == REQ_TRANSLATE) begin
          res.addr = {ent[42:3], va[11:0]};
        end
      end
    end
    return res;
  endfunction

  // called and returns at a falling edge
  task automatic send_request(req_t kind, logic [VA_BITS-1:0] va, logic [PA_BITS-1:0] pa,
                              logic usr);
    walk_result_t res;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    req_type     <= kind;
    virt_addr    <= va;
    phys_addr_in <= pa;
    user_flag    <= usr;
    do @(posedge clk); while (in_stall);
    res = walk_page_tables(kind, va, pa, usr);
    last_status = res.st;
    expected_results.push_back(res);
    kind_sent[kind]++;
    @(negedge clk);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_table_base(logic [CFG_BITS-1:0] value);
    wait_until_drained();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    base_frame = value;
  endtask

  function automatic logic [VA_BITS-1:0] pick_virt_addr();
    logic [63:0] raw;
    logic [8:0]  top;
    logic [8:0]  mid;
    logic [8:0]  low;
    logic [8:0]  leaf;
    raw = {$urandom, $urandom};
    if ($urandom_range(99) < 15) begin
      return raw[VA_BITS-1:0];
    end
    // a small set of table paths keeps walks hitting tables that already exist
    case ($urandom_range(3))
      0: top = 9'h000;
      1: top = 9'h1FF;
      2: top = 9'h0A5;
      default: top = 9'h15A;
    endcase
    mid  = $urandom_range(1) ? 9'h1FF : 9'h000;
    low  = $urandom_range(1) ? 9'h1FC : 9'h003;
    leaf = ($urandom_range(3) == 0) ? 9'($urandom) : {5'b0, 4'($urandom)};
    return {top, mid, low, leaf, raw[11:0]};
  endfunction

  function automatic logic [PA_BITS-1:0] pick_phys_addr();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return ($urandom_range(99) < 30) ? '0 : raw[PA_BITS-1:0];
  endfunction

  function automatic req_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 35) return REQ_MAP;
    if (r < 50) return REQ_UNMAP;
    if (r < 95) return REQ_TRANSLATE;
    return REQ_NONE;
  endfunction

  task automatic test_map_translate_unmap();
    send_request(REQ_TRANSLATE, 48'h0, 52'h0, 1'b0);
    send_request(REQ_UNMAP, 48'h0, 52'h0, 1'b0);
    send_request(REQ_MAP, 48'h0, 52'h0, 1'b0);
    send_request(REQ_TRANSLATE, 48'h0000_0000_0FFF, 52'h0, 1'b0);
    send_request(REQ_MAP, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 1'b1);
    send_request(REQ_TRANSLATE, 48'hFFFF_FFFF_FFFF, 52'h0, 1'b1);
    // present leaf must survive a second map
    send_request(REQ_MAP, 48'hFFFF_FFFF_F000, 52'h0_1234_5678_9000, 1'b0);
    send_request(REQ_TRANSLATE, 48'hFFFF_FFFF_F800, 52'h0, 1'b0);
    send_request(REQ_UNMAP, 48'hFFFF_FFFF_F123, 52'h0, 1'b0);
    send_request(REQ_TRANSLATE, 48'hFFFF_FFFF_F000, 52'h0, 1'b0);
    send_request(REQ_UNMAP, 48'hFFFF_FFFF_F000, 52'h0, 1'b1);
    send_request(REQ_NONE, 48'hFFFF_FFFF_FFFF, 52'hF_FFFF_FFFF_FFFF, 1'b1);
    send_request(REQ_MAP, 48'h0000_0000_1000, 52'h0_0000_0000_1FFF, 1'b1);
    send_request(REQ_TRANSLATE, 48'h0000_0000_1ABC, 52'h0, 1'b0);
  endtask

  task automatic test_table_base_moves();
    set_table_base(40'hFF_FFFF_FFFF);
    send_request(REQ_MAP, 48'h8000_0000_0123, 52'h0, 1'b1);
    send_request(REQ_TRANSLATE, 48'h8000_0000_0123, 52'h0, 1'b0);
    send_request(REQ_TRANSLATE, 48'h0, 52'h0, 1'b0);
    // old pointers now fall outside the store
    set_table_base(40'h80_0000_0000);
    send_request(REQ_TRANSLATE, 48'h8000_0000_0123, 52'h0, 1'b0);
    send_request(REQ_MAP, 48'h0, 52'h0, 1'b0);
    send_request(REQ_UNMAP, 48'h0, 52'h0, 1'b0);
    set_table_base(40'h0);
    send_request(REQ_TRANSLATE, 48'h0, 52'h0, 1'b0);
  endtask

  task automatic test_random_traffic(int count, int idle_pct, int stall_pct,
                                     logic [CFG_BITS-1:0] base);
    int n;
    set_table_base(base);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    for (n = 0; n < count; n++) begin
      send_request(pick_kind(), pick_virt_addr(), pick_phys_addr(), 1'($urandom));
    end
  endtask

  task automatic test_frame_exhaustion();
    int n;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    for (n = 0; n < 40; n++) begin
      send_request(REQ_MAP, {9'(n + 16), 39'h0}, 52'h0, 1'b1);
      if (last_status == STAT_OUT_OF_FRAMES) break;
    end
    // an existing table still takes a leaf with a given frame
    send_request(REQ_MAP, 48'h0000_0000_5000, 52'h0_00AB_CDEF_0000, 1'b0);
    send_request(REQ_TRANSLATE, 48'h0000_0000_5FFF, 52'h0, 1'b0);
  endtask

  always @(posedge clk) begin
    walk_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected transaction: addr %h status %0d", phys_addr_out, status);
        end
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        status_seen[want.st]++;
        if (phys_addr_out !== want.addr || status !== want.st) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch on result %0d: expected addr %h status %0d, got addr %h status %0d",
                     results_checked, want.addr, want.st, phys_addr_out, status);
          end
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < STORE_ENTRIES; i++) begin
      page_store[i] = '0;
    end
    free_slot  = 1;
    base_frame = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_map_translate_unmap();
    test_table_base_moves();
    test_random_traffic(480, 0, 0, 40'h0);
    test_random_traffic(480, 55, 0, 40'hFF_FFFF_FFFF);
    test_random_traffic(480, 0, 55, 40'h2);
    test_random_traffic(480, 20, 20, 40'h0);
    test_frame_exhaustion();
    wait_until_drained();

    $display("sent %0d map, %0d unmap, %0d translate, %0d unused requests; %0d results checked",
             kind_sent[REQ_MAP], kind_sent[REQ_UNMAP], kind_sent[REQ_TRANSLATE],
             kind_sent[REQ_NONE], results_checked);
    $display("outcomes: %0d ok, %0d not mapped, %0d out of frames; %0d errors",
             status_seen[STAT_OK], status_seen[STAT_NOT_MAPPED],
             status_seen[STAT_OUT_OF_FRAMES], errors);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("[four_level_page_table_engine_top] OK");
    end else begin
      $display("[four_level_page_table_engine_top] ERROR");
    end
    $finish;
  end

endmodule
